FILE: hw/rtl/sd_spi_command_sequencer_assert.svh
// Assertion macros for the SD SPI command sequencer.
`ifndef SD_SPI_COMMAND_SEQUENCER_ASSERT_SVH
`define SD_SPI_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Implication in the same cycle, checked outside reset.
`define SDSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Implication in the next cycle, checked outside reset.
`define SDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`else

`define SDSC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/sdsc_pkg.sv
// Types and constants shared by the SD SPI command sequencer modules.
package sdsc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DISCARD = 3'd1,
        PH_READY   = 3'd2,
        PH_SEND    = 3'd3,
        PH_STUFF   = 3'd4,
        PH_RESP    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_RX    = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    localparam logic [2:0] CFG_READY_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_RESP_ATTEMPTS = 3'd1;
    localparam logic [2:0] CFG_RESET_CODE    = 3'd2;
    localparam logic [2:0] CFG_IF_COND_CODE  = 3'd3;
    localparam logic [2:0] CFG_STOP_CODE     = 3'd4;

    localparam logic [7:0] RST_READY_TIMEOUT = 8'd50;
    localparam logic [7:0] RST_RESP_ATTEMPTS = 8'd10;
    localparam logic [7:0] RST_RESET_CODE    = 8'd64;
    localparam logic [7:0] RST_IF_COND_CODE  = 8'd72;
    localparam logic [7:0] RST_STOP_CODE     = 8'd76;

    localparam logic [7:0] IDLE_BYTE    = 8'hFF;
    localparam logic [7:0] CRC_RESET    = 8'h95;
    localparam logic [7:0] CRC_IF_COND  = 8'h87;
    localparam logic [7:0] CRC_NONE     = 8'h00;
    localparam logic [2:0] IDX_CRC      = 3'd4;
    localparam logic [2:0] IDX_LAST     = 3'd5;

    typedef struct packed {
        logic [7:0] ready_timeout;
        logic [7:0] resp_attempts;
        logic [7:0] reset_code;
        logic [7:0] if_cond_code;
        logic [7:0] stop_code;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  byte_index;
        logic [7:0]  ready_timer;
        logic [7:0]  attempts_left;
        logic [7:0]  latched_code;
        logic [31:0] latched_argument;
    } t_state;

    typedef struct packed {
        logic       exchange_req;
        logic [7:0] tx_byte;
        logic       done_res;
        logic [7:0] response;
        logic       busy_res;
    } t_result;

endpackage

FILE: hw/rtl/sdsc_cfg_regs.sv
// Configuration register file of the SD SPI command sequencer.
module sdsc_cfg_regs
    import sdsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_timeout <= RST_READY_TIMEOUT;
            r_cfg.resp_attempts <= RST_RESP_ATTEMPTS;
            r_cfg.reset_code    <= RST_RESET_CODE;
            r_cfg.if_cond_code  <= RST_IF_COND_CODE;
            r_cfg.stop_code     <= RST_STOP_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_READY_TIMEOUT: r_cfg.ready_timeout <= i_cfg_wdata;
                CFG_RESP_ATTEMPTS: r_cfg.resp_attempts <= i_cfg_wdata;
                CFG_RESET_CODE:    r_cfg.reset_code    <= i_cfg_wdata;
                CFG_IF_COND_CODE:  r_cfg.if_cond_code  <= i_cfg_wdata;
                CFG_STOP_CODE:     r_cfg.stop_code     <= i_cfg_wdata;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/sdsc_step.sv
// Next-state and result logic for one request of the SD SPI command sequencer.
module sdsc_step
    import sdsc_pkg::*;
(
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_cmd_code,
    input  logic [31:0] i_cmd_argument,
    input  logic [7:0]  i_rx_byte,
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    output t_state      o_state,
    output t_result     o_result
);

    t_state     n_state;
    logic [7:0] attempts_dec;
    logic [7:0] crc;
    logic [7:0] arg_byte;

    assign attempts_dec = i_state.attempts_left - 8'd1;

    // if-cond wins when both codes match
    always_comb begin
        if (i_state.latched_code == i_cfg.if_cond_code) begin
            crc = CRC_IF_COND;
        end else if (i_state.latched_code == i_cfg.reset_code) begin
            crc = CRC_RESET;
        end else begin
            crc = CRC_NONE;
        end
    end

    // argument goes out most significant byte first
    always_comb begin
        case (i_state.byte_index[1:0])
            2'd0:    arg_byte = i_state.latched_argument[31:24];
            2'd1:    arg_byte = i_state.latched_argument[23:16];
            2'd2:    arg_byte = i_state.latched_argument[15:8];
            default: arg_byte = i_state.latched_argument[7:0];
        endcase
    end

    // next state
    always_comb begin
        n_state = i_state;
        unique case (i_req_type)
            REQ_TICK: begin
                if (i_state.ready_timer != 8'd0) begin
                    n_state.ready_timer = i_state.ready_timer - 8'd1;
                end
            end
            REQ_START: begin
                if (i_state.phase == PH_IDLE) begin
                    n_state.latched_code     = i_cmd_code;
                    n_state.latched_argument = i_cmd_argument;
                    n_state.ready_timer      = i_cfg.ready_timeout;
                    n_state.byte_index       = 3'd0;
                    n_state.phase            = PH_DISCARD;
                end
            end
            REQ_RX: begin
                unique case (i_state.phase)
                    PH_IDLE: begin
                    end
                    PH_DISCARD: n_state.phase = PH_READY;
                    PH_READY: begin
                        if (i_rx_byte == IDLE_BYTE) begin
                            n_state.phase      = PH_SEND;
                            n_state.byte_index = 3'd0;
                        end else if (i_state.ready_timer == 8'd0) begin
                            n_state.phase = PH_IDLE;
                        end
                    end
                    PH_SEND: begin
                        if (i_state.byte_index < IDX_LAST) begin
                            n_state.byte_index = i_state.byte_index + 3'd1;
                        end else begin
                            n_state.byte_index = 3'd0;
                            if (i_state.latched_code == i_cfg.stop_code) begin
                                n_state.phase = PH_STUFF;
                            end else begin
                                n_state.phase         = PH_RESP;
                                n_state.attempts_left = i_cfg.resp_attempts;
                            end
                        end
                    end
                    PH_STUFF: begin
                        n_state.phase         = PH_RESP;
                        n_state.attempts_left = i_cfg.resp_attempts;
                    end
                    PH_RESP: begin
                        n_state.attempts_left = attempts_dec;
                        if (!i_rx_byte[7] || attempts_dec == 8'd0) begin
                            n_state.phase = PH_IDLE;
                        end
                    end
                    default: n_state.phase = PH_IDLE;
                endcase
            end
            default: begin
            end
        endcase
    end

    // result
    always_comb begin
        o_result = '0;
        unique case (i_req_type)
            REQ_START: begin
                if (i_state.phase == PH_IDLE) begin
                    o_result.exchange_req = 1'b1;
                    o_result.tx_byte      = IDLE_BYTE;
                end
            end
            REQ_RX: begin
                unique case (i_state.phase)
                    PH_DISCARD, PH_STUFF: begin
                        o_result.exchange_req = 1'b1;
                        o_result.tx_byte      = IDLE_BYTE;
                    end
                    PH_READY: begin
                        if (i_rx_byte == IDLE_BYTE) begin
                            o_result.exchange_req = 1'b1;
                            o_result.tx_byte      = i_state.latched_code;
                        end else if (i_state.ready_timer == 8'd0) begin
                            o_result.done_res = 1'b1;
                            o_result.response = IDLE_BYTE;
                        end else begin
                            o_result.exchange_req = 1'b1;
                            o_result.tx_byte      = IDLE_BYTE;
                        end
                    end
                    PH_SEND: begin
                        o_result.exchange_req = 1'b1;
                        if (i_state.byte_index < IDX_CRC) begin
                            o_result.tx_byte = arg_byte;
                        end else if (i_state.byte_index == IDX_CRC) begin
                            o_result.tx_byte = crc;
                        end else begin
                            o_result.tx_byte = IDLE_BYTE;
                        end
                    end
                    PH_RESP: begin
                        if (!i_rx_byte[7] || attempts_dec == 8'd0) begin
                            o_result.done_res = 1'b1;
                            o_result.response = i_rx_byte;
                        end else begin
                            o_result.exchange_req = 1'b1;
                            o_result.tx_byte      = IDLE_BYTE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        o_result.busy_res = (n_state.phase != PH_IDLE);
    end

    assign o_state = n_state;

endmodule

FILE: hw/rtl/sd_spi_command_sequencer.sv
// SD-card SPI-mode command sequencer: one request in, one result out.
// Each transfer on the input channel (start, received byte or timer tick) yields exactly one
// result, registered in the cycle after the request is taken. A new request can be taken every
// cycle: the single result register is the only stage, and input ready stays high as long as
// that register is empty or is being drained in the same cycle. Configuration registers are
// written through the plain write port and should only change while no command is running.
`include "sd_spi_command_sequencer_assert.svh"

module sd_spi_command_sequencer
    import sdsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_cmd_code,
    input  logic [31:0] i_cmd_argument,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_exchange_req,
    output logic [7:0]  o_tx_byte,
    output logic        o_done_res,
    output logic [7:0]  o_response,
    output logic        o_busy_res
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_xfer;

    sdsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sdsc_step u_step (
        .i_req_type     (i_req_type),
        .i_cmd_code     (i_cmd_code),
        .i_cmd_argument (i_cmd_argument),
        .i_rx_byte      (i_rx_byte),
        .i_cfg          (cfg),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= PH_IDLE;
            r_state.byte_index       <= 3'd0;
            r_state.ready_timer      <= 8'd0;
            r_state.attempts_left    <= 8'd0;
            r_state.latched_code     <= 8'd0;
            r_state.latched_argument <= 32'd0;
            r_out_valid              <= 1'b0;
        end else if (in_xfer) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result payload until it is taken
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_exchange_req = r_result.exchange_req;
    assign o_tx_byte      = r_result.tx_byte;
    assign o_done_res     = r_result.done_res;
    assign o_response     = r_result.response;
    assign o_busy_res     = r_result.busy_res;

    `SDSC_ASSERT_SAME(a_done_ends_cmd, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res && !o_exchange_req)
    `SDSC_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `SDSC_ASSERT_SAME(a_index_in_range, i_clk, i_rst_n, 1'b1, r_state.byte_index <= IDX_LAST)
    `SDSC_ASSERT_NEXT(a_busy_tracks_phase, i_clk, i_rst_n, in_xfer, o_busy_res == (r_state.phase != PH_IDLE))

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the SD SPI-mode command sequencer: directed table plus random.
`timescale 1ns / 1ps

module tb_top;
    import sdsc_pkg::*;

    // Request code outside the enum; the block treats it as a no-op.
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int N_ROWS = 18;
    localparam int N_PHASES = 6;

    typedef struct {
        logic [1:0]  req;
        logic [7:0]  code;
        logic [31:0] arg;
        logic [7:0]  rx;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_cmd_code = '0;
    logic [31:0] i_cmd_argument = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_exchange_req;
    logic [7:0]  o_tx_byte;
    logic        o_done_res;
    logic [7:0]  o_response;
    logic        o_busy_res;

    sd_spi_command_sequencer uut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow of the sequencer state and its settings
    t_phase      seq_phase = PH_IDLE;
    logic [2:0]  seq_index = '0;
    logic [7:0]  seq_timer = '0;
    logic [7:0]  seq_attempts = '0;
    logic [7:0]  seq_code = '0;
    logic [31:0] seq_arg = '0;
    t_cfg        seq_cfg = '{RST_READY_TIMEOUT, RST_RESP_ATTEMPTS, RST_RESET_CODE,
                             RST_IF_COND_CODE, RST_STOP_CODE};

    t_result awaited_results [$];
    int      failures = 0;
    int      results_seen = 0;
    bit      calm = 1'b0;

    t_row directed_rows [N_ROWS] = '{
        // nothing running: byte, tick and unknown code all fall through
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
        '{REQ_TICK,  8'h00, 32'h0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
        '{REQ_NONE,  8'h00, 32'h0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
        '{REQ_START, 8'h40, 32'hFFFF_FFFF, 8'h00, 1'b1, '{1'b1, 8'hFF, 1'b0, 8'h00, 1'b1}},
        // second start while busy is dropped
        '{REQ_START, 8'h00, 32'h0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b1}},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{REQ_TICK,  8'h00, 32'h0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b1}},
        '{REQ_NONE,  8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b1}},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'hFF, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'h80, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'h7F, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'hFF, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'hFF, 1'b1, '{1'b1, CRC_RESET, 1'b0, 8'h00, 1'b1}},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'hFF, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'h80, 1'b0, '0},
        '{REQ_RX,    8'h00, 32'h0000_0000, 8'h7F, 1'b1, '{1'b0, 8'h00, 1'b1, 8'h7F, 1'b0}}
    };

    function automatic t_result sequencer_result(input logic [1:0] req, input logic [7:0] code,
                                                 input logic [31:0] arg, input logic [7:0] rx);
        t_result r;
        int      sh;
        r = '0;
        case (req)
            REQ_TICK: begin
                if (seq_timer != 8'd0) seq_timer = seq_timer - 8'd1;
            end
            REQ_START: begin
                if (seq_phase == PH_IDLE) begin
                    seq_code = code;
                    seq_arg = arg;
                    seq_timer = seq_cfg.ready_timeout;
                    seq_index = '0;
                    seq_phase = PH_DISCARD;
                    r.exchange_req = 1'b1;
                    r.tx_byte = IDLE_BYTE;
                end
            end
            REQ_RX: begin
                case (seq_phase)
                    PH_DISCARD: begin
                        seq_phase = PH_READY;
                        r.exchange_req = 1'b1;
                        r.tx_byte = IDLE_BYTE;
                    end
                    PH_READY: begin
                        if (rx == IDLE_BYTE) begin
                            seq_phase = PH_SEND;
                            seq_index = '0;
                            r.exchange_req = 1'b1;
                            r.tx_byte = seq_code;
                        end else if (seq_timer == 8'd0) begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                            r.response = IDLE_BYTE;
                        end else begin
                            r.exchange_req = 1'b1;
                            r.tx_byte = IDLE_BYTE;
                        end
                    end
                    PH_SEND: begin
                        r.exchange_req = 1'b1;
                        if (seq_index < IDX_CRC) begin
                            sh = 24 - 8 * int'(seq_index);
                            r.tx_byte = 8'(seq_arg >> sh);
                            seq_index = seq_index + 3'd1;
                        end else if (seq_index == IDX_CRC) begin
                            seq_index = IDX_LAST;
                            // if-cond code wins when both codes match
                            r.tx_byte = (seq_code == seq_cfg.if_cond_code) ? CRC_IF_COND :
                                        (seq_code == seq_cfg.reset_code) ? CRC_RESET : CRC_NONE;
                        end else begin
                            seq_index = '0;
                            r.tx_byte = IDLE_BYTE;
                            if (seq_code == seq_cfg.stop_code) begin
                                seq_phase = PH_STUFF;
                            end else begin
                                seq_phase = PH_RESP;
                                seq_attempts = seq_cfg.resp_attempts;
                            end
                        end
                    end
                    PH_STUFF: begin
                        seq_phase = PH_RESP;
                        seq_attempts = seq_cfg.resp_attempts;
                        r.exchange_req = 1'b1;
                        r.tx_byte = IDLE_BYTE;
                    end
                    PH_RESP: begin
                        // zero attempts wraps to a full 256 polls
                        seq_attempts = seq_attempts - 8'd1;
                        if (!rx[7] || seq_attempts == 8'd0) begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                            r.response = rx;
                        end else begin
                            r.exchange_req = 1'b1;
                            r.tx_byte = IDLE_BYTE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    task automatic flag_failure(input string what);
        if (failures < 10) $display("%0t: %s", $realtime, what);
        failures++;
    endtask

    // Entered and left at a falling edge; drain holds off until all results are back.
    task automatic send_item(input logic [1:0] req, input logic [7:0] code,
                             input logic [31:0] arg, input logic [7:0] rx,
                             input bit typed, input t_result want, input bit drain);
        int      gap;
        t_result pred;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        if (gap > 0 || drain) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            if (drain) begin
                do @(negedge i_clk); while (awaited_results.size() != 0);
            end
        end
        i_req_type <= req;
        i_cmd_code <= code;
        i_cmd_argument <= arg;
        i_rx_byte <= rx;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pred = sequencer_result(req, code, arg, rx);
        awaited_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic draw_item(input bit closing, input int clear_pm,
                             output logic [1:0] req, output logic [7:0] code,
                             output logic [31:0] arg, output logic [7:0] rx);
        int roll;
        roll = $urandom_range(0, 99);
        req = REQ_RX;
        code = 8'($urandom);
        arg = $urandom;
        rx = 8'($urandom);
        if (closing) begin
            // steer the running command to its end
            if (seq_phase == PH_READY) rx = IDLE_BYTE;
            else if (seq_phase == PH_RESP) rx = 8'h00;
        end else if (roll < 3) begin
            req = REQ_NONE;
        end else if (roll < 10 || (seq_phase == PH_READY && roll < 30)) begin
            req = REQ_TICK;
        end else if (seq_phase == PH_IDLE) begin
            if (roll >= 16) begin
                req = REQ_START;
                case ($urandom_range(0, 5))
                    0: code = seq_cfg.reset_code;
                    1: code = seq_cfg.if_cond_code;
                    2: code = seq_cfg.stop_code;
                    default: ;
                endcase
                case ($urandom_range(0, 7))
                    0: arg = '0;
                    1: arg = '1;
                    default: ;
                endcase
            end
        end else if (roll < 14) begin
            req = REQ_START;
        end else if (seq_phase == PH_READY) begin
            if ($urandom_range(0, 99) < 55) rx = IDLE_BYTE;
        end else if (seq_phase == PH_RESP) begin
            rx[7] = ($urandom_range(0, 999) >= clear_pm);
        end
    endtask

    task automatic close_command();
        logic [1:0]  req;
        logic [7:0]  code;
        logic [31:0] arg;
        logic [7:0]  rx;
        while (seq_phase != PH_IDLE) begin
            draw_item(1'b1, 0, req, code, arg, rx);
            send_item(req, code, arg, rx, 1'b0, '0, 1'b0);
        end
    endtask

    // Write all five registers on back-to-back cycles; entered at a falling edge.
    task automatic load_settings(input t_cfg c);
        logic [2:0] idx [5];
        logic [7:0] val [5];
        idx = '{CFG_READY_TIMEOUT, CFG_RESP_ATTEMPTS, CFG_RESET_CODE, CFG_IF_COND_CODE,
                CFG_STOP_CODE};
        val = '{c.ready_timeout, c.resp_attempts, c.reset_code, c.if_cond_code, c.stop_code};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_wdata <= val[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        seq_cfg = c;
    endtask

    initial begin : stimulus
        t_cfg        plan [N_PHASES];
        int          quota [N_PHASES];
        int          clear_pm [N_PHASES];
        int          taken;
        bit          ignored;
        logic [1:0]  req;
        logic [7:0]  code;
        logic [31:0] arg;
        logic [7:0]  rx;

        plan[0] = seq_cfg;
        plan[1] = '{8'd1, 8'd1, 8'h00, 8'hFF, 8'h00};
        plan[2] = '{8'd255, 8'd255, 8'hFF, 8'h00, 8'hFF};
        plan[3] = '{8'd0, 8'd0, 8'h29, 8'h29, 8'h29};
        plan[4] = '{8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)), 8'($urandom),
                    8'($urandom), 8'($urandom)};
        plan[5] = '{RST_READY_TIMEOUT, RST_RESP_ATTEMPTS, RST_RESET_CODE, RST_IF_COND_CODE,
                    RST_STOP_CODE};
        quota = '{210, 210, 210, 400, 210, 210};
        // never clear bit 7 with zero attempts so the full wrap is walked
        clear_pm = '{250, 250, 250, 0, 250, 250};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_item(directed_rows[n].req, directed_rows[n].code, directed_rows[n].arg,
                      directed_rows[n].rx, directed_rows[n].typed, directed_rows[n].want, 1'b0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                close_command();
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (awaited_results.size() != 0);
                repeat (2) @(negedge i_clk);
                load_settings(plan[ph]);
            end
            taken = 0;
            while (taken < quota[ph]) begin
                draw_item(1'b0, clear_pm[ph], req, code, arg, rx);
                ignored = (req == REQ_NONE) || (req == REQ_START && seq_phase != PH_IDLE) ||
                          (req == REQ_RX && seq_phase == PH_IDLE);
                send_item(req, code, arg, rx, 1'b0, '0, taken == quota[ph] / 2);
                if (!ignored) taken++;
            end
        end

        close_command();
        i_in_valid <= 1'b0;
        for (int n = 0; n < 20000 && awaited_results.size() != 0; n++) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (awaited_results.size() != 0)
            flag_failure($sformatf("%0d results never arrived", awaited_results.size()));
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Alternate busy stretches with calm ones where neither side idles.
    initial begin : calm_toggle
        forever begin
            calm = 1'b0;
            repeat ($urandom_range(200, 600)) @(posedge i_clk);
            calm = 1'b1;
            repeat ($urandom_range(50, 150)) @(posedge i_clk);
        end
    end

    initial begin : result_stall
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25) hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_exchange_req, o_tx_byte, o_done_res, o_response, o_busy_res};
            if (awaited_results.size() == 0) begin
                flag_failure($sformatf("unexpected result ex=%0b tx=%02h done=%0b resp=%02h busy=%0b",
                                       got.exchange_req, got.tx_byte, got.done_res,
                                       got.response, got.busy_res));
            end else begin
                want = awaited_results.pop_front();
                if (got !== want)
                    flag_failure($sformatf({"result %0d: exp ex=%0b tx=%02h done=%0b resp=%02h ",
                                            "busy=%0b, got ex=%0b tx=%02h done=%0b resp=%02h ",
                                            "busy=%0b"}, results_seen,
                                           want.exchange_req, want.tx_byte, want.done_res,
                                           want.response, want.busy_res,
                                           got.exchange_req, got.tx_byte, got.done_res,
                                           got.response, got.busy_res));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
